[hw/rtl/gre_pkg.sv]
`default_nettype none
package gre_pkg;

    localparam int MASK_SIDE = 32;
    localparam int COL_W     = $clog2(MASK_SIDE);
    localparam int EXT_W     = $clog2(MASK_SIDE + 1);
    localparam int CELLS     = MASK_SIDE * MASK_SIDE;
    localparam int ADDR_W    = $clog2(CELLS);
    localparam int CELL_W    = 64;

    localparam int POS_W  = 5;
    localparam int SIZE_W = 6;

    localparam logic OP_WRITE   = 1'b0;
    localparam logic OP_EXTRACT = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_CK,
        ST_WID_RD,
        ST_WID_CK,
        ST_HGT_RD,
        ST_HGT_CK,
        ST_CLR,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic              operation;
        logic [POS_W-1:0]  cell_x;
        logic [POS_W-1:0]  cell_y;
        logic [CELL_W-1:0] cell_word;
    } op_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [CELL_W-1:0] wdata;
    } mem_req_t;

    typedef struct packed {
        logic              found;
        logic [POS_W-1:0]  x;
        logic [POS_W-1:0]  y;
        logic [SIZE_W-1:0] width;
        logic [SIZE_W-1:0] height;
        logic [CELL_W-1:0] cell_word;
    } face_t;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [COL_W-1:0] x,
                                                    input logic [COL_W-1:0] y);
        logic [ADDR_W+COL_W:0] prod;
        prod = (ADDR_W+COL_W+1)'(y) * (ADDR_W+COL_W+1)'(MASK_SIDE)
             + (ADDR_W+COL_W+1)'(x);
        return prod[ADDR_W-1:0];
    endfunction

endpackage
`default_nettype wire

[hw/rtl/greedy_rectangle_extractor.sv]
// Greedy rectangle extractor over a 32 x 32 mask of 64-bit cells.
// Input channel (s_): one beat is an operation. A write (s_operation = 0)
// stores block, color and texture words at (s_cell_x, s_cell_y) and moves
// the scan position back to the origin, and it produces
// no result beat. An extract (s_operation = 1) produces exactly one beat
// on the result channel (m_): the next rectangle of equal cells in
// row-major order, which is then cleared from the mask, or m_face_found
// low with all other fields zero once the mask is empty.
// Every cell must be written before the first extract.
// An extract scans for the next occupied cell, grows the row to the
// right, grows downward row by row and then clears the rectangle. The
// cell memory is single-port with a registered read; one operation is
// in flight at a time.
// A finished result waits in an output register while a new operation is
// accepted; a stalled receiver holds the block only when the next result
// is ready. Reset clears the scan position and the control state; the
// mask contents are left as they are.
`default_nettype none
module greedy_rectangle_extractor (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic                        s_operation,
    input  wire logic [4:0]                  s_cell_x,
    input  wire logic [4:0]                  s_cell_y,
    input  wire logic [15:0]                 s_block_word,
    input  wire logic [15:0]                 s_color_word,
    input  wire logic [31:0]                 s_texture_word,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic                             m_face_found,
    output logic [4:0]                       m_face_x,
    output logic [4:0]                       m_face_y,
    output logic [5:0]                       m_face_width,
    output logic [5:0]                       m_face_height,
    output logic [15:0]                      m_face_block,
    output logic [15:0]                      m_face_color,
    output logic [31:0]                      m_face_texture
);
    import gre_pkg::*;

    op_t               op;
    mem_req_t          mem_req;
    logic [CELL_W-1:0] rd_data;
    logic              res_valid;
    face_t             res;
    logic              out_free;
    logic              m_valid_reg;
    face_t             face_reg;

    assign op.operation = s_operation;
    assign op.cell_x    = s_cell_x;
    assign op.cell_y    = s_cell_y;
    assign op.cell_word = {s_texture_word, s_color_word, s_block_word};

    assign out_free = !m_valid_reg || m_ready;

    gre_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .op_valid  (s_valid),
        .op        (op),
        .op_ready  (s_ready),
        .mem_req   (mem_req),
        .rd_data   (rd_data),
        .res_valid (res_valid),
        .res       (res),
        .out_free  (out_free)
    );

    gre_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_cells (
        .aclk  (aclk),
        .we    (mem_req.we),
        .addr  (mem_req.addr),
        .wdata (mem_req.wdata),
        .rdata (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && res_valid) begin
            face_reg <= res;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_face_found   = face_reg.found;
    assign m_face_x       = face_reg.x;
    assign m_face_y       = face_reg.y;
    assign m_face_width   = face_reg.width;
    assign m_face_height  = face_reg.height;
    assign m_face_block   = face_reg.cell_word[15:0];
    assign m_face_color   = face_reg.cell_word[31:16];
    assign m_face_texture = face_reg.cell_word[63:32];
endmodule
`default_nettype wire

[hw/rtl/gre_ram.sv]
`default_nettype none
module gre_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;
endmodule
`default_nettype wire

[hw/rtl/gre_ctrl.sv]
`default_nettype none
module gre_ctrl (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      op_valid,
    input  wire gre_pkg::op_t              op,
    output logic                           op_ready,
    output gre_pkg::mem_req_t              mem_req,
    input  wire logic [gre_pkg::CELL_W-1:0] rd_data,
    output logic                           res_valid,
    output gre_pkg::face_t                 res,
    input  wire logic                      out_free
);
    import gre_pkg::*;

    state_t            state_reg, state_next;
    logic [COL_W-1:0]  scan_col_reg;
    logic [EXT_W-1:0]  scan_row_reg;
    logic [COL_W-1:0]  x0_reg, y0_reg, wx_reg, wy_reg;
    logic [EXT_W-1:0]  xe_reg, ye_reg;
    logic [CELL_W-1:0] cur_reg;
    logic              found_reg;

    logic              op_fire;
    logic              wr_in_range;
    logic              scan_end;
    logic              x_last;
    logic              cx_last;
    logic              cy_last;
    logic [EXT_W-1:0]  wx_inc;
    logic [EXT_W-1:0]  wy_inc;

    assign op_fire     = op_valid && op_ready;
    assign wr_in_range = (EXT_W+1)'(op.cell_x) < (EXT_W+1)'(MASK_SIDE)
                      && (EXT_W+1)'(op.cell_y) < (EXT_W+1)'(MASK_SIDE);
    assign scan_end    = scan_row_reg == EXT_W'(MASK_SIDE);
    assign wx_inc      = EXT_W'(wx_reg) + EXT_W'(1);
    assign wy_inc      = EXT_W'(wy_reg) + EXT_W'(1);
    assign x_last      = wx_inc == xe_reg;
    assign cx_last     = x_last;
    assign cy_last     = wy_inc == ye_reg;

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (op_fire && op.operation == OP_EXTRACT) begin
                    state_next = ST_SCAN_RD;
                end
            end
            ST_SCAN_RD: state_next = scan_end ? ST_DONE : ST_SCAN_CK;
            ST_SCAN_CK: state_next = (rd_data != '0) ? ST_WID_RD : ST_SCAN_RD;
            ST_WID_RD:  state_next = (xe_reg == EXT_W'(MASK_SIDE)) ? ST_HGT_RD : ST_WID_CK;
            ST_WID_CK:  state_next = (rd_data == cur_reg) ? ST_WID_RD : ST_HGT_RD;
            ST_HGT_RD:  state_next = (ye_reg == EXT_W'(MASK_SIDE)) ? ST_CLR : ST_HGT_CK;
            ST_HGT_CK:  state_next = (rd_data != cur_reg) ? ST_CLR : ST_HGT_RD;
            ST_CLR:     state_next = (cx_last && cy_last) ? ST_DONE : ST_CLR;
            ST_DONE:    state_next = out_free ? ST_IDLE : ST_DONE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // Outputs: handshake, memory port and result.
    always_comb begin
        op_ready      = 1'b0;
        mem_req.we    = 1'b0;
        mem_req.addr  = '0;
        mem_req.wdata = '0;
        res_valid     = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                op_ready      = 1'b1;
                mem_req.we    = op_fire && op.operation == OP_WRITE && wr_in_range;
                mem_req.addr  = cell_addr(COL_W'(op.cell_x), COL_W'(op.cell_y));
                mem_req.wdata = op.cell_word;
            end
            ST_SCAN_RD: mem_req.addr = cell_addr(scan_col_reg, COL_W'(scan_row_reg));
            ST_WID_RD:  mem_req.addr = cell_addr(COL_W'(xe_reg), y0_reg);
            ST_HGT_RD:  mem_req.addr = cell_addr(wx_reg, COL_W'(ye_reg));
            ST_CLR: begin
                mem_req.we   = 1'b1;
                mem_req.addr = cell_addr(wx_reg, wy_reg);
            end
            ST_DONE:    res_valid = 1'b1;
            default: begin
            end
        endcase
        res.found     = found_reg;
        res.x         = found_reg ? POS_W'(x0_reg) : '0;
        res.y         = found_reg ? POS_W'(y0_reg) : '0;
        res.width     = found_reg ? SIZE_W'(xe_reg - EXT_W'(x0_reg)) : '0;
        res.height    = found_reg ? SIZE_W'(ye_reg - EXT_W'(y0_reg)) : '0;
        res.cell_word = found_reg ? cur_reg : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            scan_col_reg <= '0;
            scan_row_reg <= '0;
            found_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            case (state_reg)
                ST_IDLE: begin
                    if (op_fire && op.operation == OP_WRITE) begin
                        scan_col_reg <= '0;
                        scan_row_reg <= '0;
                    end
                end
                ST_SCAN_RD: begin
                    if (scan_end) begin
                        found_reg <= 1'b0;
                    end
                end
                ST_SCAN_CK: begin
                    if (rd_data != '0) begin
                        found_reg <= 1'b1;
                    end else if (scan_col_reg == COL_W'(MASK_SIDE - 1)) begin
                        scan_col_reg <= '0;
                        scan_row_reg <= scan_row_reg + EXT_W'(1);
                    end else begin
                        scan_col_reg <= scan_col_reg + COL_W'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Rectangle datapath.
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_SCAN_CK: begin
                cur_reg <= rd_data;
                x0_reg  <= scan_col_reg;
                y0_reg  <= COL_W'(scan_row_reg);
                xe_reg  <= EXT_W'(scan_col_reg) + EXT_W'(1);
            end
            ST_WID_RD: begin
                if (xe_reg == EXT_W'(MASK_SIDE)) begin
                    ye_reg <= EXT_W'(y0_reg) + EXT_W'(1);
                    wx_reg <= x0_reg;
                end
            end
            ST_WID_CK: begin
                if (rd_data == cur_reg) begin
                    xe_reg <= xe_reg + EXT_W'(1);
                end else begin
                    ye_reg <= EXT_W'(y0_reg) + EXT_W'(1);
                    wx_reg <= x0_reg;
                end
            end
            ST_HGT_RD: begin
                if (ye_reg == EXT_W'(MASK_SIDE)) begin
                    wx_reg <= x0_reg;
                    wy_reg <= y0_reg;
                end
            end
            ST_HGT_CK: begin
                if (rd_data != cur_reg) begin
                    wx_reg <= x0_reg;
                    wy_reg <= y0_reg;
                end else if (x_last) begin
                    // The whole span of this row matched: take the row.
                    ye_reg <= ye_reg + EXT_W'(1);
                    wx_reg <= x0_reg;
                end else begin
                    wx_reg <= wx_reg + COL_W'(1);
                end
            end
            ST_CLR: begin
                if (cx_last) begin
                    wx_reg <= x0_reg;
                    wy_reg <= wy_reg + COL_W'(1);
                end else begin
                    wx_reg <= wx_reg + COL_W'(1);
                end
            end
            default: begin
            end
        endcase
    end
endmodule
`default_nettype wire

[bench/greedy_rectangle_extractor_tb.sv]
`timescale 1ns / 1ps

module greedy_rectangle_extractor_tb;
    import gre_pkg::*;

    typedef struct {
        logic        found;
        logic [4:0]  x;
        logic [4:0]  y;
        logic [5:0]  width;
        logic [5:0]  height;
        logic [15:0] block_part;
        logic [15:0] color_part;
        logic [31:0] texture_part;
    } rect_result_t;

    // Mirrors the mask and the saved scan position, and queues the face that
    // each accepted extract beat must return.
    class face_scoreboard;
        logic [63:0]  cells [0:MASK_SIDE-1][0:MASK_SIDE-1];
        int unsigned  scan_row;
        int unsigned  scan_col;
        rect_result_t pending_faces [$];
        int unsigned  errors;
        bit           last_found;

        function new();
            foreach (cells[y, x]) cells[y][x] = '0;
            scan_row = 0;
            scan_col = 0;
            errors = 0;
            last_found = 1'b0;
        endfunction

        function rect_result_t carve_next_face();
            rect_result_t face;
            logic [63:0]  cur;
            int unsigned  x0, y0, xe, ye;
            bit           hit, same;
            face = '{default: '0};
            hit = 1'b0;
            while (scan_row < MASK_SIDE && !hit) begin
                if (cells[scan_row][scan_col] != '0) begin
                    hit = 1'b1;
                end else if (scan_col == MASK_SIDE - 1) begin
                    scan_col = 0;
                    scan_row++;
                end else begin
                    scan_col++;
                end
            end
            if (!hit) begin
                // The scan stays parked past the last row until a write.
                scan_col = 0;
                return face;
            end
            x0 = scan_col;
            y0 = scan_row;
            cur = cells[y0][x0];
            xe = x0;
            while (xe < MASK_SIDE && cells[y0][xe] == cur) xe++;
            ye = y0;
            same = 1'b1;
            while (ye < MASK_SIDE && same) begin
                for (int unsigned x = x0; x < xe; x++) begin
                    if (cells[ye][x] != cur) same = 1'b0;
                end
                if (same) ye++;
            end
            for (int unsigned y = y0; y < ye; y++)
                for (int unsigned x = x0; x < xe; x++)
                    cells[y][x] = '0;
            face.found = 1'b1;
            face.x = x0[4:0];
            face.y = y0[4:0];
            face.width = 6'(xe - x0);
            face.height = 6'(ye - y0);
            face.block_part = cur[15:0];
            face.color_part = cur[31:16];
            face.texture_part = cur[63:32];
            return face;
        endfunction

        function void note_beat(logic op, logic [4:0] x, logic [4:0] y, logic [63:0] word);
            rect_result_t face;
            if (op == OP_WRITE) begin
                cells[y][x] = word;
                scan_row = 0;
                scan_col = 0;
            end else begin
                face = carve_next_face();
                last_found = face.found;
                pending_faces.insert(pending_faces.size(), face);
            end
        endfunction

        function void report_mismatch(string field, logic [63:0] want, logic [63:0] got);
            errors++;
            if (errors <= 40)
                $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
        endfunction

        function void check_face(rect_result_t got);
            rect_result_t want;
            if (pending_faces.size() == 0) begin
                report_mismatch("unexpected face beat, found", 64'(1'bx), 64'(got.found));
                return;
            end
            want = pending_faces.pop_front();
            if (got.found !== want.found)
                report_mismatch("face_found", 64'(want.found), 64'(got.found));
            if (got.x !== want.x)
                report_mismatch("face_x", 64'(want.x), 64'(got.x));
            if (got.y !== want.y)
                report_mismatch("face_y", 64'(want.y), 64'(got.y));
            if (got.width !== want.width)
                report_mismatch("face_width", 64'(want.width), 64'(got.width));
            if (got.height !== want.height)
                report_mismatch("face_height", 64'(want.height), 64'(got.height));
            if (got.block_part !== want.block_part)
                report_mismatch("face_block", 64'(want.block_part), 64'(got.block_part));
            if (got.color_part !== want.color_part)
                report_mismatch("face_color", 64'(want.color_part), 64'(got.color_part));
            if (got.texture_part !== want.texture_part)
                report_mismatch("face_texture", 64'(want.texture_part), 64'(got.texture_part));
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_operation = OP_WRITE;
    logic [4:0]  s_cell_x = '0;
    logic [4:0]  s_cell_y = '0;
    logic [15:0] s_block_word = '0;
    logic [15:0] s_color_word = '0;
    logic [31:0] s_texture_word = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_face_found;
    logic [4:0]  m_face_x;
    logic [4:0]  m_face_y;
    logic [5:0]  m_face_width;
    logic [5:0]  m_face_height;
    logic [15:0] m_face_block;
    logic [15:0] m_face_color;
    logic [31:0] m_face_texture;

    face_scoreboard sb;
    bit             src_idle = 1'b0;
    bit             sink_idle = 1'b0;
    int             sink_hold = 0;
    int unsigned    beats_sent = 0;

    greedy_rectangle_extractor i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_operation    (s_operation),
        .s_cell_x       (s_cell_x),
        .s_cell_y       (s_cell_y),
        .s_block_word   (s_block_word),
        .s_color_word   (s_color_word),
        .s_texture_word (s_texture_word),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_face_found   (m_face_found),
        .m_face_x       (m_face_x),
        .m_face_y       (m_face_y),
        .m_face_width   (m_face_width),
        .m_face_height  (m_face_height),
        .m_face_block   (m_face_block),
        .m_face_color   (m_face_color),
        .m_face_texture (m_face_texture)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Receiver stalls come in bursts, started at random while sink_idle is set.
    always @(posedge aclk) begin
        if (sink_hold > 0) begin
            sink_hold--;
            m_ready <= 1'b0;
        end else if (aresetn && sink_idle && $urandom_range(0, 7) == 0) begin
            sink_hold = $urandom_range(0, 16);
            m_ready <= 1'b0;
        end else begin
            m_ready <= aresetn;
        end
    end

    always @(posedge aclk) begin
        rect_result_t got;
        if (aresetn && m_valid && m_ready) begin
            got.found = m_face_found;
            got.x = m_face_x;
            got.y = m_face_y;
            got.width = m_face_width;
            got.height = m_face_height;
            got.block_part = m_face_block;
            got.color_part = m_face_color;
            got.texture_part = m_face_texture;
            sb.check_face(got);
        end
    end

    task automatic send_beat(input logic op, input logic [4:0] x, input logic [4:0] y,
                             input logic [63:0] word);
        s_valid <= 1'b1;
        s_operation <= op;
        s_cell_x <= x;
        s_cell_y <= y;
        s_block_word <= word[15:0];
        s_color_word <= word[31:16];
        s_texture_word <= word[63:32];
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_beat(op, x, y, word);
        beats_sent++;
        if (src_idle && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge aclk);
        end
    endtask

    // The payload of an extract carries no meaning, so it is left random.
    task automatic send_extract();
        send_beat(OP_EXTRACT, 5'($urandom), 5'($urandom), {$urandom, $urandom});
    endtask

    task automatic drain_mask();
        int guard;
        guard = 0;
        do begin
            send_extract();
            guard++;
        end while (sb.last_found && guard < CELLS + 1);
    endtask

    function automatic logic [63:0] pick_cell();
        case ($urandom_range(0, 9))
            0: return '1;
            1: return {$urandom, 32'h0};
            2: return {48'h0, 16'($urandom_range(1, 65535))};
            3: return {32'h0, 16'($urandom_range(1, 65535)), 16'h0};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Writes a clipped rectangle of one value, now and then with a stray cell
    // that breaks it up.
    task automatic paint_rect(input int x0, input int y0, input int w, input int h,
                              input logic [63:0] word);
        for (int y = y0; y < y0 + h && y < MASK_SIDE; y++) begin
            for (int x = x0; x < x0 + w && x < MASK_SIDE; x++) begin
                if ($urandom_range(0, 19) == 0)
                    send_beat(OP_WRITE, x[4:0], y[4:0], pick_cell());
                else
                    send_beat(OP_WRITE, x[4:0], y[4:0], word);
            end
        end
    endtask

    task automatic random_round();
        logic [63:0] palette [3];
        int          n;
        int          w;
        int          h;
        for (int i = 0; i < 3; i++) palette[i] = pick_cell();
        if ($urandom_range(0, 9) < 7) begin
            n = $urandom_range(1, 3);
            for (int i = 0; i < n; i++) begin
                if ($urandom_range(0, 19) == 0) begin
                    w = $urandom_range(1, MASK_SIDE);
                    h = $urandom_range(1, 3);
                end else begin
                    w = $urandom_range(1, 6);
                    h = $urandom_range(1, 6);
                end
                paint_rect($urandom_range(0, MASK_SIDE - 1), $urandom_range(0, MASK_SIDE - 1),
                           w, h, palette[$urandom_range(0, 2)]);
            end
        end else begin
            n = $urandom_range(1, 8);
            for (int i = 0; i < n; i++)
                send_beat(OP_WRITE, 5'($urandom), 5'($urandom),
                          ($urandom_range(0, 3) == 0) ? 64'h0 : pick_cell());
        end
        if ($urandom_range(0, 3) == 0)
            drain_mask();
        else
            repeat ($urandom_range(1, 6)) send_extract();
    endtask

    initial begin
        int unsigned mark;
        sb = new();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Every cell must hold a known value before the first extract; one
        // value everywhere gives a full-mask face.
        src_idle = 1'b1;
        sink_idle = 1'b1;
        for (int y = 0; y < MASK_SIDE; y++)
            for (int x = 0; x < MASK_SIDE; x++)
                send_beat(OP_WRITE, x[4:0], y[4:0], '1);

        send_extract();
        send_extract();
        send_extract();
        send_beat(OP_WRITE, 5'd31, 5'd31, 64'h8000_0001_8001_8001);
        send_extract();
        send_extract();
        // A cell with only one nonzero part is still occupied.
        send_beat(OP_WRITE, 5'd0, 5'd0, 64'h0000_0001_0000_0000);
        send_beat(OP_WRITE, 5'd1, 5'd0, 64'h0000_0000_0000_0001);
        send_beat(OP_WRITE, 5'd2, 5'd0, 64'h0000_0000_0001_0000);
        send_extract();
        send_extract();
        send_extract();
        send_extract();
        // A corner differing only in its top texture bit stops the row growth.
        send_beat(OP_WRITE, 5'd4, 5'd5, 64'h1234_5678_9ABC_DEF0);
        send_beat(OP_WRITE, 5'd5, 5'd5, 64'h1234_5678_9ABC_DEF0);
        send_beat(OP_WRITE, 5'd4, 5'd6, 64'h1234_5678_9ABC_DEF0);
        send_beat(OP_WRITE, 5'd5, 5'd6, 64'h9234_5678_9ABC_DEF0);
        send_extract();
        send_extract();
        send_extract();
        send_extract();

        mark = beats_sent;
        while (beats_sent - mark < 150) begin
            src_idle = ($urandom_range(0, 3) != 0);
            sink_idle = ($urandom_range(0, 3) != 0);
            random_round();
        end
        src_idle = 1'b0;
        sink_idle = 1'b0;
        while (beats_sent - mark < 280) random_round();
        drain_mask();
        s_valid <= 1'b0;

        while (sb.pending_faces.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (sb.errors == 0 && sb.pending_faces.size() == 0) begin
            $display("** greedy_rectangle_extractor: PASSED **");
        end else begin
            $display("** greedy_rectangle_extractor: FAILED **");
        end
        $finish;
    end

    initial begin
        #200ms;
        $display("** greedy_rectangle_extractor: FAILED **");
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/gre_pkg.sv
hw/rtl/gre_ram.sv
hw/rtl/gre_ctrl.sv
hw/rtl/greedy_rectangle_extractor.sv
bench/greedy_rectangle_extractor_tb.sv
